// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/clrs_pkg.sv
// ---------------------------------------------------------------------------
// clrs_pkg
// shared widths, register codes and structs of the contour line-run segmenter
// ---------------------------------------------------------------------------
package clrs_pkg;

    // contour capacity, points beyond it are dropped
    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // item field widths
    localparam int ANG_W   = 17;
    localparam int GRAD_W  = 17;
    localparam int COORD_W = 12;
    localparam int OIDX_W  = 12;
    localparam int CEN_W   = 16;

    // register widths and reset values
    localparam int LGL_W = 16;
    localparam int MGL_W = 12;
    localparam int MAL_W = 16;
    localparam logic [LGL_W-1:0] LGL_RESET = LGL_W'(48);
    localparam logic [MGL_W-1:0] MGL_RESET = MGL_W'(20);
    localparam logic [MAL_W-1:0] MAL_RESET = MAL_W'(80);

    // register indexes on the config port
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_GRAD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MERGE_GAP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MERGE_ANG = 2'd2;

    // sums and division
    localparam int ASUM_W = ANG_W + IDX_W + 1;
    localparam int CSUM_W = COORD_W + IDX_W;
    localparam int NPT_W  = IDX_W + 1;
    localparam int DEN_W  = NPT_W + 1;
    localparam int NUM_W  = (ASUM_W + 1 > CSUM_W + 6) ? ASUM_W + 1 : CSUM_W + 6;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int GAP_W  = (IDX_W > MGL_W) ? IDX_W : MGL_W;

    // segment queue, depth a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream and config port widths
    localparam int ANG_LSB    = 0;
    localparam int GRAD_LSB   = ANG_LSB + ANG_W;
    localparam int X_LSB      = GRAD_LSB + GRAD_W;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 80;
    localparam int M_USER_W   = 2;
    localparam int USER_EMPTY = 0;
    localparam int USER_OVF   = 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [LGL_W-1:0] line_grad;
        logic [MGL_W-1:0] merge_gap;
        logic [MAL_W-1:0] merge_ang;
    } cfg_t;

    // one finished segment waiting for its means
    typedef struct packed {
        logic [IDX_W-1:0]         first_idx;
        logic [IDX_W-1:0]         end_idx;
        logic signed [ASUM_W-1:0] sum_ang;
        logic [CSUM_W-1:0]        sum_x;
        logic [CSUM_W-1:0]        sum_y;
        logic                     last_seg;
        logic                     empty;
        logic                     ovf;
    } seg_t;

    typedef struct packed {
        logic [1:0] count;
        seg_t       first;
        seg_t       second;
    } qpush_t;

    typedef struct packed {
        logic room2;
        logic avail;
    } qstat_t;

endpackage

// File: src/clrs_fifo.sv
// ---------------------------------------------------------------------------
// clrs_fifo
// short segment queue between front and back, up to two writes per cycle
// ---------------------------------------------------------------------------
module clrs_fifo import clrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qpush_t push,
    input  logic   pop,
    output seg_t   head,
    output qstat_t stat
);

    seg_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  wr_ptr_inc;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;

    assign wr_ptr_inc  = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.avail = (cnt_reg != '0);
    assign stat.room2 = (cnt_reg <= QCNT_W'(QDEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: src/clrs_div.sv
// ---------------------------------------------------------------------------
// clrs_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module clrs_div import clrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0]  acc_reg;
    logic [NUM_W-1:0]  acc_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = numer;
            rem_next  = '0;
            den_next  = denom;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[NUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign quot = acc_reg;

endmodule

// File: src/clrs_front.sv
// ---------------------------------------------------------------------------
// clrs_front
// point classifier: run and gap sums, run closing, merge and segment issue
// ---------------------------------------------------------------------------
module clrs_front import clrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  qstat_t              qstat,
    output qpush_t              push
);

    localparam logic F_TAKE   = 1'b0;
    localparam logic F_FINISH = 1'b1;

    logic state_reg, state_next;

    // contour control
    logic [CNT_W-1:0] pi_reg, pi_next;
    logic in_run_reg, in_run_next;
    logic p_valid_reg, p_valid_next;
    logic dropped_reg, dropped_next;
    logic close_reg, close_next;
    logic last_reg, last_next;
    logic hold_gap_reg, hold_gap_next;

    // pending segment
    logic [IDX_W-1:0]         p_start_reg, p_start_next;
    logic [IDX_W-1:0]         p_end_reg, p_end_next;
    logic signed [ANG_W-1:0]  p_ang_reg, p_ang_next;
    logic signed [ASUM_W-1:0] p_sa_reg, p_sa_next;
    logic [CSUM_W-1:0]        p_sx_reg, p_sx_next;
    logic [CSUM_W-1:0]        p_sy_reg, p_sy_next;

    // gap sums since the pending segment
    logic signed [ASUM_W-1:0] g_sa_reg, g_sa_next;
    logic [CSUM_W-1:0]        g_sx_reg, g_sx_next;
    logic [CSUM_W-1:0]        g_sy_reg, g_sy_next;

    // open run
    logic [IDX_W-1:0]         r_start_reg, r_start_next;
    logic [IDX_W-1:0]         r_last_reg, r_last_next;
    logic signed [ANG_W-1:0]  r_begin_reg, r_begin_next;
    logic signed [ANG_W-1:0]  r_end_reg, r_end_next;
    logic signed [ASUM_W-1:0] r_sa_reg, r_sa_next;
    logic [CSUM_W-1:0]        r_sx_reg, r_sx_next;
    logic [CSUM_W-1:0]        r_sy_reg, r_sy_next;

    // point held for the gap sums
    logic signed [ANG_W-1:0]  h_ang_reg, h_ang_next;
    logic [COORD_W-1:0]       h_x_reg, h_x_next;
    logic [COORD_W-1:0]       h_y_reg, h_y_next;

    logic signed [ANG_W-1:0]  ang_in;
    logic [GRAD_W-1:0]        grad_in;
    logic [GRAD_W-1:0]        grad_mag;
    logic [COORD_W-1:0]       x_in;
    logic [COORD_W-1:0]       y_in;
    logic                     straight;
    logic                     full;
    logic                     take;
    logic [IDX_W-1:0]         gap_idx;
    logic                     gap_ok;
    logic signed [ANG_W:0]    ang_diff;
    logic [ANG_W:0]           ang_mag;
    logic                     ang_ok;
    logic                     merge;
    logic                     emit_a;
    logic                     emit_b;
    seg_t                     seg_a;
    seg_t                     seg_b;

    assign ang_in   = s_tdata[ANG_LSB +: ANG_W];
    assign grad_in  = s_tdata[GRAD_LSB +: GRAD_W];
    assign x_in     = s_tdata[X_LSB +: COORD_W];
    assign y_in     = s_tdata[Y_LSB +: COORD_W];
    assign grad_mag = grad_in[GRAD_W-1] ? GRAD_W'(~grad_in + 1'b1) : grad_in;
    assign straight = (grad_mag <= GRAD_W'(cfg.line_grad));
    assign full     = (pi_reg == CNT_W'(MAX_POINTS));

    assign s_tready = (state_reg == F_TAKE) && qstat.room2;
    assign take     = s_tvalid && s_tready;

    // merge test of the closing run against the pending segment
    assign gap_idx  = r_start_reg - p_end_reg;
    assign gap_ok   = (r_start_reg > p_end_reg) && (GAP_W'(gap_idx) < GAP_W'(cfg.merge_gap));
    assign ang_diff = (ANG_W+1)'(r_end_reg) - (ANG_W+1)'(p_ang_reg);
    assign ang_mag  = ang_diff[ANG_W] ? (ANG_W+1)'(~ang_diff + 1'b1) : ang_diff;
    assign ang_ok   = (ang_mag < (ANG_W+1)'(cfg.merge_ang));
    assign merge    = p_valid_reg && gap_ok && ang_ok;

    always_comb
    begin
        state_next    = state_reg;
        pi_next       = pi_reg;
        in_run_next   = in_run_reg;
        p_valid_next  = p_valid_reg;
        dropped_next  = dropped_reg;
        close_next    = close_reg;
        last_next     = last_reg;
        hold_gap_next = hold_gap_reg;
        p_start_next  = p_start_reg;
        p_end_next    = p_end_reg;
        p_ang_next    = p_ang_reg;
        p_sa_next     = p_sa_reg;
        p_sx_next     = p_sx_reg;
        p_sy_next     = p_sy_reg;
        g_sa_next     = g_sa_reg;
        g_sx_next     = g_sx_reg;
        g_sy_next     = g_sy_reg;
        r_start_next  = r_start_reg;
        r_last_next   = r_last_reg;
        r_begin_next  = r_begin_reg;
        r_end_next    = r_end_reg;
        r_sa_next     = r_sa_reg;
        r_sx_next     = r_sx_reg;
        r_sy_next     = r_sy_reg;
        h_ang_next    = h_ang_reg;
        h_x_next      = h_x_reg;
        h_y_next      = h_y_reg;
        emit_a        = 1'b0;
        emit_b        = 1'b0;
        seg_a         = '0;
        seg_b         = '0;

        unique case (state_reg)
            F_TAKE:
            begin
                if (take)
                begin
                    h_ang_next    = ang_in;
                    h_x_next      = x_in;
                    h_y_next      = y_in;
                    hold_gap_next = 1'b0;
                    if (!full)
                    begin
                        if (straight)
                        begin
                            if (!in_run_reg)
                            begin
                                r_start_next = pi_reg[IDX_W-1:0];
                                r_begin_next = ang_in;
                                r_sa_next    = ASUM_W'(ang_in);
                                r_sx_next    = CSUM_W'(x_in);
                                r_sy_next    = CSUM_W'(y_in);
                            end
                            else
                            begin
                                r_sa_next = r_sa_reg + ASUM_W'(ang_in);
                                r_sx_next = r_sx_reg + CSUM_W'(x_in);
                                r_sy_next = r_sy_reg + CSUM_W'(y_in);
                            end
                            r_last_next = pi_reg[IDX_W-1:0];
                            r_end_next  = ang_in;
                            in_run_next = 1'b1;
                        end
                        else
                        begin
                            hold_gap_next = 1'b1;
                        end
                        pi_next = pi_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    // a bent point ends the run, the contour end closes any open run
                    close_next = (!full && !straight && in_run_reg)
                              || (s_tlast && (in_run_reg || (!full && straight)));
                    last_next  = s_tlast;
                    state_next = F_FINISH;
                end
            end

            F_FINISH:
            begin
                if (close_reg)
                begin
                    in_run_next = 1'b0;
                    g_sa_next   = '0;
                    g_sx_next   = '0;
                    g_sy_next   = '0;
                    if (merge)
                    begin
                        p_sa_next  = p_sa_reg + g_sa_reg + r_sa_reg;
                        p_sx_next  = p_sx_reg + g_sx_reg + r_sx_reg;
                        p_sy_next  = p_sy_reg + g_sy_reg + r_sy_reg;
                        p_end_next = r_last_reg;
                    end
                    else
                    begin
                        emit_a          = p_valid_reg;
                        seg_a.first_idx = p_start_reg;
                        seg_a.end_idx   = p_end_reg;
                        seg_a.sum_ang   = p_sa_reg;
                        seg_a.sum_x     = p_sx_reg;
                        seg_a.sum_y     = p_sy_reg;
                        p_valid_next    = 1'b1;
                        p_start_next    = r_start_reg;
                        p_end_next      = r_last_reg;
                        p_ang_next      = r_begin_reg;
                        p_sa_next       = r_sa_reg;
                        p_sx_next       = r_sx_reg;
                        p_sy_next       = r_sy_reg;
                    end
                end
                if (hold_gap_reg)
                begin
                    g_sa_next = g_sa_next + ASUM_W'(h_ang_reg);
                    g_sx_next = g_sx_next + CSUM_W'(h_x_reg);
                    g_sy_next = g_sy_next + CSUM_W'(h_y_reg);
                end
                if (last_reg)
                begin
                    emit_b         = 1'b1;
                    seg_b.last_seg = 1'b1;
                    seg_b.ovf      = dropped_reg;
                    if (p_valid_next)
                    begin
                        seg_b.first_idx = p_start_next;
                        seg_b.end_idx   = p_end_next;
                        seg_b.sum_ang   = p_sa_next;
                        seg_b.sum_x     = p_sx_next;
                        seg_b.sum_y     = p_sy_next;
                    end
                    else
                    begin
                        seg_b.empty = 1'b1;
                    end
                    // contour done, registers stay
                    pi_next      = '0;
                    in_run_next  = 1'b0;
                    p_valid_next = 1'b0;
                    dropped_next = 1'b0;
                    g_sa_next    = '0;
                    g_sx_next    = '0;
                    g_sy_next    = '0;
                end
                state_next = F_TAKE;
            end

            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    assign push.count  = {1'b0, emit_a} + {1'b0, emit_b};
    assign push.first  = emit_a ? seg_a : seg_b;
    assign push.second = seg_b;

    always_ff @(posedge clk)
    begin
        p_start_reg <= p_start_next;
        p_end_reg   <= p_end_next;
        p_ang_reg   <= p_ang_next;
        p_sa_reg    <= p_sa_next;
        p_sx_reg    <= p_sx_next;
        p_sy_reg    <= p_sy_next;
        r_start_reg <= r_start_next;
        r_last_reg  <= r_last_next;
        r_begin_reg <= r_begin_next;
        r_end_reg   <= r_end_next;
        r_sa_reg    <= r_sa_next;
        r_sx_reg    <= r_sx_next;
        r_sy_reg    <= r_sy_next;
        h_ang_reg   <= h_ang_next;
        h_x_reg     <= h_x_next;
        h_y_reg     <= h_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_TAKE;
            pi_reg       <= '0;
            in_run_reg   <= 1'b0;
            p_valid_reg  <= 1'b0;
            dropped_reg  <= 1'b0;
            close_reg    <= 1'b0;
            last_reg     <= 1'b0;
            hold_gap_reg <= 1'b0;
            g_sa_reg     <= '0;
            g_sx_reg     <= '0;
            g_sy_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pi_reg       <= pi_next;
            in_run_reg   <= in_run_next;
            p_valid_reg  <= p_valid_next;
            dropped_reg  <= dropped_next;
            close_reg    <= close_next;
            last_reg     <= last_next;
            hold_gap_reg <= hold_gap_next;
            g_sa_reg     <= g_sa_next;
            g_sx_reg     <= g_sx_next;
            g_sy_reg     <= g_sy_next;
        end
    end

endmodule

// File: src/clrs_back.sv
// ---------------------------------------------------------------------------
// clrs_back
// segment means: three divider lanes and the result register
// ---------------------------------------------------------------------------
module clrs_back import clrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  seg_t                head,
    input  qstat_t              qstat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic [M_USER_W-1:0] m_tuser
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;
    logic [M_USER_W-1:0] out_user_reg, out_user_next;

    logic [IDX_W-1:0] s_idx_reg, s_idx_next;
    logic [IDX_W-1:0] e_idx_reg, e_idx_next;
    logic neg_reg, neg_next;
    logic last_reg, last_next;
    logic empty_reg, empty_next;
    logic ovf_reg, ovf_next;

    logic                    start_div;
    logic                    load;
    logic                    div_busy;
    logic                    busy_a, busy_x, busy_y;
    logic [NPT_W-1:0]        npts;
    logic [NUM_W-1:0]        n_ext;
    logic signed [NUM_W-1:0] s2;
    logic [NUM_W-1:0]        num_a, num_x, num_y;
    logic [DEN_W-1:0]        den;
    logic [NUM_W-1:0]        q_a, q_x, q_y;
    logic [ANG_W-1:0]        mean;

    // rounding to nearest: (2*s + n) / (2*n), mirrored for negative angle sums
    assign npts  = NPT_W'(head.end_idx) - NPT_W'(head.first_idx) + NPT_W'(1);
    assign n_ext = NUM_W'(npts);
    assign den   = {npts, 1'b0};
    assign s2    = NUM_W'(head.sum_ang) <<< 1;
    assign num_a = head.sum_ang[ASUM_W-1] ? n_ext - s2 : s2 + n_ext;
    assign num_x = (NUM_W'(head.sum_x) << 5) + n_ext;
    assign num_y = (NUM_W'(head.sum_y) << 5) + n_ext;

    assign start_div = (state_reg == B_IDLE) && qstat.avail;
    assign pop       = start_div;
    assign div_busy  = busy_a || busy_x || busy_y;
    assign load      = (state_reg == B_RUN) && !div_busy && (!out_valid_reg || m_tready);
    assign mean      = neg_reg ? ANG_W'(-ANG_W'(q_a)) : ANG_W'(q_a);

    clrs_div u_div_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_div),
        .numer (num_a),
        .denom (den),
        .busy  (busy_a),
        .quot  (q_a)
    );

    clrs_div u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_div),
        .numer (num_x),
        .denom (den),
        .busy  (busy_x),
        .quot  (q_x)
    );

    clrs_div u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_div),
        .numer (num_y),
        .denom (den),
        .busy  (busy_y),
        .quot  (q_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        s_idx_next     = s_idx_reg;
        e_idx_next     = e_idx_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ovf_next       = ovf_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (start_div)
                begin
                    s_idx_next = head.first_idx;
                    e_idx_next = head.end_idx;
                    neg_next   = head.sum_ang[ASUM_W-1];
                    last_next  = head.last_seg;
                    empty_next = head.empty;
                    ovf_next   = head.ovf;
                    state_next = B_RUN;
                end
            end

            B_RUN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_DATA_W'({CEN_W'(q_y), CEN_W'(q_x), mean,
                                                OIDX_W'(e_idx_reg), OIDX_W'(s_idx_reg)});
                    out_last_next  = last_reg;
                    out_user_next  = {ovf_reg, empty_reg};
                    state_next     = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
        s_idx_reg    <= s_idx_next;
        e_idx_reg    <= e_idx_next;
        neg_reg      <= neg_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        ovf_reg      <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: src/contour_line_run_segmenter_unit.sv
// ---------------------------------------------------------------------------
// contour_line_run_segmenter_unit
// splits a contour point stream into straight segments with mean angle/center
// ---------------------------------------------------------------------------
// the front takes a point in its accept state, then closes or merges in its finish state;
// it takes no new point in between, nor while the queue lacks room for two segments
// segment means come from the bit-serial dividers, which the back runs one segment at a time
// a 4-entry segment queue absorbs bursts of short runs between front and back
// reset (rst_n low, async): contour state and queue cleared, registers 48/20/80
// ---------------------------------------------------------------------------
module contour_line_run_segmenter_unit import clrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // point stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // direction_angle[16:0], angle_gradient[33:17], point_x[45:34], point_y[57:46]
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,     // last_point

    // segment stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // start_index[11:0], end_index[23:12], mean_angle[40:24],
    // center_x[56:41], center_y[72:57]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,     // last_segment
    // empty_contour[0], overflow[1]
    output logic [M_USER_W-1:0]   m_tuser,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LGL_W-1:0]     lgl_reg;
    logic [MGL_W-1:0]     mgl_reg;
    logic [MAL_W-1:0]     mal_reg;
    logic                 reg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    cfg_t                 cfg;
    qpush_t               qpush;
    qstat_t               qstat;
    seg_t                 qhead;
    logic                 qpop;

    // registers sit at word addresses, no wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lgl_reg <= LGL_RESET;
            mgl_reg <= MGL_RESET;
            mal_reg <= MAL_RESET;
        end
        else if (reg_wr)
        begin
            // writes past the register list fall through
            unique case (reg_idx)
                REG_LINE_GRAD: lgl_reg <= pwdata[LGL_W-1:0];
                REG_MERGE_GAP: mgl_reg <= pwdata[MGL_W-1:0];
                REG_MERGE_ANG: mal_reg <= pwdata[MAL_W-1:0];
                default:       lgl_reg <= lgl_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LINE_GRAD: prdata = APB_DATA_W'(lgl_reg);
            REG_MERGE_GAP: prdata = APB_DATA_W'(mgl_reg);
            REG_MERGE_ANG: prdata = APB_DATA_W'(mal_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.line_grad = lgl_reg;
    assign cfg.merge_gap = mgl_reg;
    assign cfg.merge_ang = mal_reg;

    // front: classify points, keep run/gap/pending sums, issue segments
    clrs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (qpush)
    );

    // segment queue, the front only takes a point with room for two segments
    clrs_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (qpush),
        .pop   (qpop),
        .head  (qhead),
        .stat  (qstat)
    );

    // back: rounded means and the output register
    clrs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (qhead),
        .qstat    (qstat),
        .pop      (qpop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: src/clrs_checker.sv
// ---------------------------------------------------------------------------
// clrs_checker
// port-level checks of the segment stream, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clrs_checker import clrs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tlast,
    input logic [M_USER_W-1:0]   m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // an empty contour gives one final item with zero fields
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, m_tvalid && m_tuser[USER_EMPTY], m_tlast && (m_tdata == '0))

    // overflow only on the final item of a contour
    `ASSERT_IMPL(a_ovf_last, clk, rst_n, m_tvalid && m_tuser[USER_OVF], m_tlast)

    // a segment never ends before it starts
    `ASSERT_IMPL(a_idx_order, clk, rst_n, m_tvalid && !m_tuser[USER_EMPTY], m_tdata[2*OIDX_W-1:OIDX_W] >= m_tdata[OIDX_W-1:0])

endmodule

bind contour_line_run_segmenter_unit clrs_checker u_clrs_checker (.*);

// File: test/contour_line_run_segmenter_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// contour_line_run_segmenter_unit_tb
// streams contours of points through the segmenter and checks every segment
// item against a cycle-free predictor of the run/merge/mean rules, across
// several register settings, idling patterns and back pressure
// ---------------------------------------------------------------------------
module contour_line_run_segmenter_unit_tb;
    import clrs_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    // front end plus one full division pass, with margin
    localparam int DRAIN_CYCLES = 80;
    // register index past the end of the register map, writes are dropped
    localparam int REG_UNMAPPED = 3;

    // one contour point as it enters the block
    typedef struct {
        logic signed [ANG_W-1:0]  angle;
        logic signed [GRAD_W-1:0] grad;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic                     last;
    } point_t;

    // one segment item as it leaves the block
    typedef struct packed {
        logic [OIDX_W-1:0] first_idx;
        logic [OIDX_W-1:0] end_idx;
        logic [ANG_W-1:0]  mean_ang;
        logic [CEN_W-1:0]  cen_x;
        logic [CEN_W-1:0]  cen_y;
        logic              last_seg;
        logic              empty;
        logic              ovf;
    } segment_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // idling odds in percent, and a long receiver hold-off counted down below
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold     = 0;

    int error_count = 0;
    int points_sent = 0;
    int cycle_count = 0;

    // segments still owed by the block, oldest first
    segment_t expected_segments[$];

    // predictor copy of the registers
    longint lim_gradient;
    longint lim_gap;
    longint lim_angle;

    // predictor copy of the contour state
    int     pt_count;
    bit     run_open;
    bit     held_valid;
    int     held_first;
    int     held_last;
    longint held_first_angle;
    longint held_sum[3];     // angle, x, y
    longint gap_sum[3];
    int     run_first;
    int     run_last_idx;
    longint run_first_angle;
    longint run_last_angle;
    longint run_sum[3];
    bit     lost_points;

    contour_line_run_segmenter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // error reporting, only the first ten are printed
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want !== got)
            flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    // nearest integer, halves away from zero (centers are never negative,
    // so for them this is the same as halves up)
    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic void clear_contour();
        pt_count         = 0;
        run_open         = 1'b0;
        held_valid       = 1'b0;
        held_first       = 0;
        held_last        = 0;
        held_first_angle = 0;
        held_sum         = '{0, 0, 0};
        gap_sum          = '{0, 0, 0};
        run_first        = 0;
        run_last_idx     = 0;
        run_first_angle  = 0;
        run_last_angle   = 0;
        run_sum          = '{0, 0, 0};
        lost_points      = 1'b0;
    endfunction

    // emit the held segment, or an empty-contour marker when none is held
    function automatic void push_segment(bit is_last);
        segment_t seg;
        longint   n;
        seg = '0;
        if (held_valid)
        begin
            n = held_last - held_first + 1;
            if (n < 1)
                n = 1;
            seg.first_idx = OIDX_W'(held_first);
            seg.end_idx   = OIDX_W'(held_last);
            seg.mean_ang  = ANG_W'(round_div(held_sum[0], n));
            seg.cen_x     = CEN_W'(round_div(16 * held_sum[1], n));
            seg.cen_y     = CEN_W'(round_div(16 * held_sum[2], n));
        end
        else
        begin
            seg.empty = 1'b1;
        end
        seg.last_seg = is_last;
        seg.ovf      = is_last && lost_points;
        expected_segments.insert(expected_segments.size(), seg);
    endfunction

    // a finished run either joins the held segment (gap points included)
    // or pushes it out and takes its place
    function automatic void close_straight_run();
        longint diff;
        int     gap;
        int     k;
        run_open = 1'b0;
        if (held_valid)
        begin
            gap  = run_first - held_last;
            diff = run_last_angle - held_first_angle;
            if (diff < 0)
                diff = -diff;
            if (run_first > held_last && gap < lim_gap && diff < lim_angle)
            begin
                for (k = 0; k < 3; k++)
                    held_sum[k] += gap_sum[k] + run_sum[k];
                held_last = run_last_idx;
                gap_sum   = '{0, 0, 0};
                return;
            end
            push_segment(1'b0);
        end
        held_valid       = 1'b1;
        held_first       = run_first;
        held_last        = run_last_idx;
        held_first_angle = run_first_angle;
        held_sum         = run_sum;
        gap_sum          = '{0, 0, 0};
    endfunction

    function automatic void predict_point(point_t p);
        longint ang;
        longint grad;
        if (pt_count >= MAX_POINTS)
        begin
            // beyond capacity: dropped, but its last flag still counts
            lost_points = 1'b1;
        end
        else
        begin
            ang  = p.angle;
            grad = p.grad;
            if (grad < 0)
                grad = -grad;
            if (grad <= lim_gradient)
            begin
                if (!run_open)
                begin
                    run_open        = 1'b1;
                    run_first       = pt_count;
                    run_first_angle = ang;
                    run_sum         = '{0, 0, 0};
                end
                run_last_idx   = pt_count;
                run_last_angle = ang;
                run_sum[0] += ang;
                run_sum[1] += p.x;
                run_sum[2] += p.y;
            end
            else
            begin
                if (run_open)
                    close_straight_run();
                gap_sum[0] += ang;
                gap_sum[1] += p.x;
                gap_sum[2] += p.y;
            end
            pt_count++;
        end
        if (p.last)
        begin
            if (run_open)
                close_straight_run();
            push_segment(1'b1);
            clear_contour();
        end
    endfunction

    // ------------------------------------------------------------------
    // segment checker, every accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        segment_t got;
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.first_idx = m_tdata[11:0];
            got.end_idx   = m_tdata[23:12];
            got.mean_ang  = m_tdata[40:24];
            got.cen_x     = m_tdata[56:41];
            got.cen_y     = m_tdata[72:57];
            got.last_seg  = m_tlast;
            got.empty     = m_tuser[USER_EMPTY];
            got.ovf       = m_tuser[USER_OVF];
            if (expected_segments.size() == 0)
            begin
                flag_mismatch($sformatf("segment item with none expected: %h", got));
            end
            else
            begin
                want = expected_segments.pop_front();
                check_field("start_index", want.first_idx, got.first_idx);
                check_field("end_index", want.end_idx, got.end_idx);
                check_field("mean_angle", longint'($signed(want.mean_ang)),
                            longint'($signed(got.mean_ang)));
                check_field("center_x", want.cen_x, got.cen_x);
                check_field("center_y", want.cen_y, got.cen_y);
                check_field("last_segment", want.last_seg, got.last_seg);
                check_field("empty_contour", want.empty, got.empty);
                check_field("overflow", want.ovf, got.ovf);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off while recv_hold counts down
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // offer one point, with random idle cycles first; valid stays high after
    // acceptance so back-to-back items need no drop in between
    task automatic send_point(input point_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.y, p.x, p.grad, p.angle};
        s_tlast  <= p.last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_point(p);
        points_sent++;
    endtask

    // sender stops, all owed segments arrive, then the block gets time to settle
    task automatic wait_for_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one two-phase register access; the register changes at the access edge
    task automatic reg_access(input bit is_write, input int idx, input longint value,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (is_write)
        begin
            if (idx == REG_LINE_GRAD)
                lim_gradient = value & 16'hFFFF;
            else if (idx == REG_MERGE_GAP)
                lim_gap = value & 12'hFFF;
            else if (idx == REG_MERGE_ANG)
                lim_angle = value & 16'hFFFF;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_registers();
        logic [APB_DATA_W-1:0] rdata;
        reg_access(1'b0, REG_LINE_GRAD, 0, rdata);
        check_field("line_gradient_limit readback", lim_gradient, rdata);
        reg_access(1'b0, REG_MERGE_GAP, 0, rdata);
        check_field("merge_gap_limit readback", lim_gap, rdata);
        reg_access(1'b0, REG_MERGE_ANG, 0, rdata);
        check_field("merge_angle_limit readback", lim_angle, rdata);
    endtask

    // new limits, only once the block has gone quiet
    task automatic set_limits(input longint grad_lim, input longint gap_lim,
                              input longint ang_lim);
        logic [APB_DATA_W-1:0] rdata;
        wait_for_idle();
        reg_access(1'b1, REG_LINE_GRAD, grad_lim, rdata);
        reg_access(1'b1, REG_MERGE_GAP, gap_lim, rdata);
        reg_access(1'b1, REG_MERGE_ANG, ang_lim, rdata);
        check_registers();
    endtask

    function automatic point_t make_point(longint ang, longint grad, int x, int y,
                                          bit last);
        point_t p;
        p.angle = ANG_W'(ang);
        p.grad  = GRAD_W'(grad);
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        p.last  = last;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // contour generator: blocks of straight and bent points with a slowly
    // drifting angle so that runs often merge, plus some pure noise points
    // ------------------------------------------------------------------
    task automatic send_contour(input int n_pts);
        longint base;
        longint mag;
        longint grad;
        bit     straight;
        int     left;
        int     i;
        point_t p;
        base = longint'($urandom_range(0, 131071)) - 65536;
        left = 0;
        straight = 1'b0;
        for (i = 0; i < n_pts; i++)
        begin
            if (left == 0)
            begin
                straight = ($urandom_range(99) < 60);
                left = straight ? $urandom_range(1, 8) : $urandom_range(1, 4);
                if ($urandom_range(9) == 0)
                    base += longint'($urandom_range(0, 400)) - 200;
            end
            left--;
            base += longint'($urandom_range(0, 16)) - 8;
            if (base < -65536)
                base = -65536;
            if (base > 65535)
                base = 65535;
            if (straight)
            begin
                mag = ($urandom_range(3) == 0) ? lim_gradient
                                               : longint'($urandom_range(0, lim_gradient));
                grad = $urandom_range(1) ? -mag : mag;
            end
            else if (lim_gradient >= 65535)
            begin
                // only the most negative gradient is bent at this setting
                grad = -65536;
            end
            else
            begin
                mag = ($urandom_range(3) == 0) ? lim_gradient + 1
                          : longint'($urandom_range(lim_gradient + 1, 65536));
                grad = (mag == 65536 || $urandom_range(1)) ? -mag : mag;
            end
            p = make_point(base, grad, $urandom_range(0, 4095), $urandom_range(0, 4095),
                           i == n_pts - 1);
            if ($urandom_range(9) == 0)
            begin
                // noise point, every bit pattern of angle and gradient
                p.angle = ANG_W'($urandom);
                p.grad  = GRAD_W'($urandom);
            end
            send_point(p);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        check_registers();
    endtask

    // hand-built contours for the edge cases
    task automatic test_directed_points();
        // single straight point at the field extremes
        send_point(make_point(-65536, 0, 4095, 4095, 1'b1));
        // single bent point: empty contour
        send_point(make_point(65535, -65536, 4095, 0, 1'b1));
        // gradient right at the limit, one gap point, close run merged at the end
        send_point(make_point(65535, 48, 0, 0, 1'b0));
        send_point(make_point(65530, -48, 4095, 0, 1'b0));
        send_point(make_point(100, 49, 17, 4000, 1'b0));
        send_point(make_point(65500, 0, 1, 2, 1'b0));
        send_point(make_point(65520, 10, 2048, 2047, 1'b1));
        // negative tie rounds away from zero; the last point closes a run that
        // cannot merge, giving two segment items from one point
        send_point(make_point(-1, 0, 0, 1, 1'b0));
        send_point(make_point(-2, 0, 1, 0, 1'b0));
        send_point(make_point(0, 60000, 5, 5, 1'b0));
        send_point(make_point(5000, 1, 3, 3, 1'b0));
        send_point(make_point(5001, -1, 3, 4, 1'b1));
        // positive tie rounds up
        send_point(make_point(1, 0, 0, 0, 1'b0));
        send_point(make_point(2, 0, 1, 1, 1'b1));
    endtask

    task automatic test_random_contours(input int n_items);
        int target;
        target = points_sent + n_items;
        while (points_sent < target)
        begin
            if ($urandom_range(19) == 0)
                send_contour($urandom_range(25, 60));
            else
                send_contour($urandom_range(1, 24));
        end
    endtask

    // a write past the register map must leave every register as it was
    task automatic test_unmapped_register();
        logic [APB_DATA_W-1:0] rdata;
        wait_for_idle();
        reg_access(1'b1, REG_UNMAPPED, $urandom, rdata);
        check_registers();
    endtask

    // receiver holds off long enough for the segment queue to fill and the
    // input to stall, then the sender waits for every owed segment
    task automatic test_backpressure();
        wait_for_idle();
        recv_hold = 600;
        test_random_contours(60);
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        lim_gradient = LGL_RESET;
        lim_gap      = MGL_RESET;
        lim_angle    = MAL_RESET;
        clear_contour();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles often, receiver more often
        send_idle_pct = 33;
        recv_idle_pct = 57;
        test_register_reset();
        test_directed_points();
        test_random_contours(250);
        // strictest straightness, loosest merging
        set_limits(0, 4095, 65535);
        test_random_contours(150);

        // roles swapped
        wait_for_idle();
        send_idle_pct = 57;
        recv_idle_pct = 33;
        // everything straight but the most negative gradient, merging off
        set_limits(65535, 0, 0);
        test_random_contours(150);
        test_unmapped_register();
        set_limits($urandom_range(1, 200), $urandom_range(2, 40), $urandom_range(1, 600));
        test_random_contours(250);
        test_backpressure();

        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(LGL_RESET, MGL_RESET, MAL_RESET);
        test_random_contours(100);
        set_limits($urandom_range(1, 200), $urandom_range(2, 40), $urandom_range(1, 600));
        test_random_contours(150);

        wait_for_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
